// File: hw/rtl/alusf_pkg.sv
// Shared constants and types for the ALU with status flags.
// Holds the operation codes and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package alusf_pkg;

  localparam int DataWidthDefault = 32;
  localparam int OpWidth          = 4;
  localparam int ShiftWidth       = 5;

  localparam logic [OpWidth-1:0] OP_ADD = 4'd0;
  localparam logic [OpWidth-1:0] OP_SUB = 4'd1;
  localparam logic [OpWidth-1:0] OP_MUL = 4'd2;
  localparam logic [OpWidth-1:0] OP_DIV = 4'd3;
  localparam logic [OpWidth-1:0] OP_AND = 4'd4;
  localparam logic [OpWidth-1:0] OP_OR  = 4'd5;
  localparam logic [OpWidth-1:0] OP_XOR = 4'd6;
  localparam logic [OpWidth-1:0] OP_NOT = 4'd7;
  localparam logic [OpWidth-1:0] OP_SHL = 4'd8;
  localparam logic [OpWidth-1:0] OP_SHR = 4'd9;
  localparam logic [OpWidth-1:0] OP_EQ  = 4'd10;
  localparam logic [OpWidth-1:0] OP_NEQ = 4'd11;
  localparam logic [OpWidth-1:0] OP_GT  = 4'd12;
  localparam logic [OpWidth-1:0] OP_LT  = 4'd13;
  localparam logic [OpWidth-1:0] OP_GE  = 4'd14;
  localparam logic [OpWidth-1:0] OP_LE  = 4'd15;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } alusf_cmd_t;

  typedef struct packed {
    logic long_op;
  } alusf_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/alusf_ctrl.sv
// Controller for the ALU with status flags: input/output handshake and iteration count.
// Depends on alusf_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module alusf_ctrl
  import alusf_pkg::*;
#(
  parameter int DATA_WIDTH = DataWidthDefault
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire alusf_status_t status,
  output alusf_cmd_t         cmd
);

  localparam int CntWidth = $clog2(DATA_WIDTH + 1);
  localparam logic [CntWidth-1:0] IterCount = CntWidth'(DATA_WIDTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ITER = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [CntWidth-1:0] count;
  logic                out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.long_op ? S_ITER : S_FIN;
        end
      end
      S_ITER: begin
        cmd.step = 1'b1;
        if (count == CntWidth'(1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        count <= IterCount;
      end else if (cmd.step) begin
        count <= count - CntWidth'(1);
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/alusf_dp.sv
// Datapath for the ALU with status flags: operand registers, shared shift-add
// multiply / restoring divide unit, result logic, status flags and result register.
// Depends on alusf_pkg for operation codes and command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module alusf_dp
  import alusf_pkg::*;
#(
  parameter int DATA_WIDTH = DataWidthDefault
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire alusf_cmd_t            cmd,
  output alusf_status_t              status,
  input  wire logic [OpWidth-1:0]    req_type,
  input  wire logic [DATA_WIDTH-1:0] operand_a,
  input  wire logic [DATA_WIDTH-1:0] operand_b,
  output logic [DATA_WIDTH-1:0]      result_value,
  output logic                       zero_flag,
  output logic                       negative_flag,
  output logic                       overflow_flag,
  output logic                       divide_error,
  output logic                       halt_state
);

  localparam int W = DATA_WIDTH;
  localparam int CmpWidth = $clog2(W + 1) + 1;

  logic [OpWidth-1:0] op;
  logic [W-1:0]       a;
  logic [W-1:0]       b;
  logic [W-1:0]       x;
  logic [W-1:0]       y;
  logic [W-1:0]       acc;

  logic               st_z;
  logic               st_n;
  logic               st_o;
  logic               halt;

  logic [W-1:0]       mag_a;
  logic [W-1:0]       mag_b;
  logic [W:0]         diff;
  logic [W-1:0]       rem_shift;

  logic [W-1:0]       res;
  logic               ovf;
  logic               derr;
  logic [W-1:0]       sum;
  logic [W-1:0]       dif;
  logic [CmpWidth-1:0] sh_ext;
  logic               sa_lt_b;
  logic               sb_lt_a;

  assign status.long_op = (req_type == OP_MUL) ||
                          ((req_type == OP_DIV) && (operand_b != '0));

  assign mag_a = operand_a[W-1] ? (~operand_a + W'(1)) : operand_a;
  assign mag_b = operand_b[W-1] ? (~operand_b + W'(1)) : operand_b;

  assign rem_shift = {acc[W-2:0], x[W-1]};
  assign diff      = {acc, x[W-1]} - {1'b0, y};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= req_type;
      a   <= operand_a;
      b   <= operand_b;
      acc <= '0;
      if (req_type == OP_DIV) begin
        x <= mag_a;
        y <= mag_b;
      end else begin
        x <= operand_a;
        y <= operand_b;
      end
    end else if (cmd.step) begin
      if (op == OP_DIV) begin
        if (!diff[W]) begin
          acc <= diff[W-1:0];
          x   <= {x[W-2:0], 1'b1};
        end else begin
          acc <= rem_shift;
          x   <= {x[W-2:0], 1'b0};
        end
      end else begin
        if (y[0]) begin
          acc <= acc + x;
        end
        x <= {x[W-2:0], 1'b0};
        y <= {1'b0, y[W-1:1]};
      end
    end
  end

  assign sum     = a + b;
  assign dif     = a - b;
  assign sh_ext  = CmpWidth'(b[ShiftWidth-1:0]);
  assign sa_lt_b = $signed(a) < $signed(b);
  assign sb_lt_a = $signed(b) < $signed(a);

  always_comb begin
    res  = '0;
    ovf  = 1'b0;
    derr = 1'b0;
    case (op)
      OP_ADD: begin
        res = sum;
        ovf = (a[W-1] ^ sum[W-1]) & (b[W-1] ^ sum[W-1]);
      end
      OP_SUB: begin
        res = dif;
        ovf = (a[W-1] ^ b[W-1]) & (a[W-1] ^ dif[W-1]);
      end
      OP_MUL: res = acc;
      OP_DIV: begin
        if (b == '0) begin
          derr = 1'b1;
        end else begin
          res = (a[W-1] ^ b[W-1]) ? (~x + W'(1)) : x;
        end
      end
      OP_AND: res = a & b;
      OP_OR:  res = a | b;
      OP_XOR: res = a ^ b;
      OP_NOT: res = ~a;
      OP_SHL: res = (sh_ext >= CmpWidth'(W)) ? '0 : (a << b[ShiftWidth-1:0]);
      OP_SHR: res = (sh_ext >= CmpWidth'(W)) ? '0 : (a >> b[ShiftWidth-1:0]);
      OP_EQ:  res = W'(a == b);
      OP_NEQ: res = W'(a != b);
      OP_GT:  res = W'(sb_lt_a);
      OP_LT:  res = W'(sa_lt_b);
      OP_GE:  res = W'(!sa_lt_b);
      OP_LE:  res = W'(!sb_lt_a);
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_z <= 1'b0;
      st_n <= 1'b0;
      st_o <= 1'b0;
      halt <= 1'b0;
    end else if (cmd.commit) begin
      if (derr) begin
        halt <= 1'b1;
      end else begin
        st_z <= (res == '0);
        st_n <= res[W-1];
        st_o <= ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result_value  <= res;
      divide_error  <= derr;
      halt_state    <= halt | derr;
      zero_flag     <= derr ? st_z : (res == '0);
      negative_flag <= derr ? st_n : res[W-1];
      overflow_flag <= derr ? st_o : ovf;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/alu_with_status_flags_core.sv
// Top level of the ALU with status flags: stream ports, controller and datapath.
// Depends on alusf_pkg, alusf_ctrl and alusf_dp.
//
// One beat in gives one beat out. Logic, shift, add, subtract and compare
// operations go from acceptance straight to the finish state, which loads the
// result register. Multiply and divide go through a shared shift-add /
// restoring-divide unit one bit per cycle in the iteration state, then the
// finish state loads the result register. A divide by zero skips the
// iterations, returns 0 with divide_error set, keeps the flags and sets
// halt_state until reset. The block takes one item at a time. A new beat is
// accepted while the previous result waits in the output register. A finished
// result then holds until that register is free, and the input stalls for as
// long as it holds.
`timescale 1ns / 1ps
`default_nettype none

module alu_with_status_flags_core
  import alusf_pkg::*;
#(
  parameter int DATA_WIDTH = DataWidthDefault
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // req_type[3:0], operand_a, operand_b, zero padding
  input  wire logic [((OpWidth+2*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // result_value, zero_flag, negative_flag, overflow_flag, divide_error,
  // halt_state, zero padding
  output logic [((DATA_WIDTH+5+7)/8)*8-1:0]          m_axis_tdata
);

  localparam int OutWidth = ((DATA_WIDTH + 5 + 7) / 8) * 8;
  localparam int OutPad   = OutWidth - DATA_WIDTH - 5;

  alusf_cmd_t             cmd;
  alusf_status_t          status;
  logic [DATA_WIDTH-1:0]  result_value;
  logic                   zero_flag;
  logic                   negative_flag;
  logic                   overflow_flag;
  logic                   divide_error;
  logic                   halt_state;
  logic [OutWidth-1:0]    out_word;

  alusf_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  alusf_dp #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .req_type     (s_axis_tdata[OpWidth-1:0]),
    .operand_a    (s_axis_tdata[OpWidth+DATA_WIDTH-1:OpWidth]),
    .operand_b    (s_axis_tdata[OpWidth+2*DATA_WIDTH-1:OpWidth+DATA_WIDTH]),
    .result_value (result_value),
    .zero_flag    (zero_flag),
    .negative_flag(negative_flag),
    .overflow_flag(overflow_flag),
    .divide_error (divide_error),
    .halt_state   (halt_state)
  );

  assign out_word = {{OutPad{1'b0}}, halt_state, divide_error, overflow_flag,
                     negative_flag, zero_flag, result_value};
  assign m_axis_tdata = out_word;

endmodule

`default_nettype wire

// File: tb/alu_with_status_flags_core_tb.sv
// Self-checking testbench for alu_with_status_flags_core: directed corner cases, then random beats.
// A scoreboard class predicts each result beat and the stored flags and checks them in order.
// Depends on alusf_pkg and the alu_with_status_flags_core RTL.
`timescale 1ns / 1ps

module alu_with_status_flags_core_tb;
  import alusf_pkg::*;

  localparam int DW          = DataWidthDefault;
  localparam int IN_BITS     = ((OpWidth + 2 * DW + 7) / 8) * 8;
  localparam int OUT_BITS    = ((DW + 5 + 7) / 8) * 8;
  localparam int RANDOM_BEATS = 1350;
  localparam int CALM_FROM   = 1200;
  localparam int LONG_HOLD   = 90;
  localparam int STALL_LIMIT = 5000;

  localparam logic [DW-1:0] MIN_VAL  = {1'b1, {(DW - 1){1'b0}}};
  localparam logic [DW-1:0] MAX_VAL  = {1'b0, {(DW - 1){1'b1}}};
  localparam logic [DW-1:0] ALL_ONES = {DW{1'b1}};

  typedef struct packed {
    logic          halt;
    logic          div_err;
    logic          ovf;
    logic          neg;
    logic          zero;
    logic [DW-1:0] value;
  } alu_result_t;

  class alu_flag_predictor;
    alu_result_t expected_results[$];
    logic        zf, nf, vf, halted;
    int unsigned mismatches;

    function new();
      zf = 1'b0;
      nf = 1'b0;
      vf = 1'b0;
      halted = 1'b0;
      mismatches = 0;
    endfunction

    function void note_request(logic [OpWidth-1:0] op, logic [DW-1:0] a, logic [DW-1:0] b);
      alu_result_t res;
      logic [DW-1:0] r, mag_a, mag_b, quo;
      logic ovf, derr;
      r = '0;
      ovf = 1'b0;
      derr = 1'b0;
      mag_a = a[DW-1] ? -a : a;
      mag_b = b[DW-1] ? -b : b;
      case (op)
        OP_ADD: begin
          r = a + b;
          ovf = (a[DW-1] == b[DW-1]) && (r[DW-1] != a[DW-1]);
        end
        OP_SUB: begin
          r = a - b;
          ovf = (a[DW-1] != b[DW-1]) && (r[DW-1] != a[DW-1]);
        end
        OP_MUL: r = a * b;
        OP_DIV: begin
          if (b == '0) begin
            derr = 1'b1;
          end else begin
            quo = mag_a / mag_b;
            r = (a[DW-1] ^ b[DW-1]) ? -quo : quo;
          end
        end
        OP_AND: r = a & b;
        OP_OR:  r = a | b;
        OP_XOR: r = a ^ b;
        OP_NOT: r = ~a;
        OP_SHL: r = a << b[ShiftWidth-1:0];
        OP_SHR: r = a >> b[ShiftWidth-1:0];
        OP_EQ:  r = {{(DW - 1){1'b0}}, a == b};
        OP_NEQ: r = {{(DW - 1){1'b0}}, a != b};
        OP_GT:  r = {{(DW - 1){1'b0}}, $signed(a) > $signed(b)};
        OP_LT:  r = {{(DW - 1){1'b0}}, $signed(a) < $signed(b)};
        OP_GE:  r = {{(DW - 1){1'b0}}, $signed(a) >= $signed(b)};
        OP_LE:  r = {{(DW - 1){1'b0}}, $signed(a) <= $signed(b)};
      endcase
      if (derr) begin
        halted = 1'b1;
      end else begin
        zf = (r == '0);
        nf = r[DW-1];
        vf = ovf;
      end
      res.value = r;
      res.zero = zf;
      res.neg = nf;
      res.ovf = vf;
      res.div_err = derr;
      res.halt = halted;
      expected_results.push_back(res);
    endfunction

    function void report(string field, logic [DW-1:0] want, logic [DW-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [OUT_BITS-1:0] beat);
      alu_result_t got, want;
      got = beat[$bits(alu_result_t)-1:0];
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, beat);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      report("result_value", want.value, got.value);
      report("zero_flag", want.zero, got.zero);
      report("negative_flag", want.neg, got.neg);
      report("overflow_flag", want.ovf, got.ovf);
      report("divide_error", want.div_err, got.div_err);
      report("halt_state", want.halt, got.halt);
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // req_type, operand_a, operand_b, zero padding
  logic [IN_BITS-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // result_value, zero_flag, negative_flag, overflow_flag, divide_error, halt_state, padding
  logic [OUT_BITS-1:0] m_axis_tdata;

  alu_flag_predictor book;
  int                idle_pct;
  logic              long_hold;
  int unsigned       quiet_cycles;

  alu_with_status_flags_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [DW-1:0] pick_operand();
    logic [DW-1:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 5))
          0: v = '0;
          1: v = 1;
          2: v = ALL_ONES;
          3: v = MIN_VAL;
          4: v = MAX_VAL;
          default: v = MIN_VAL + 1;
        endcase
      end
      1: begin
        v = $urandom_range(0, 16);
        if ($urandom_range(0, 1)) v = -v;
      end
      2: begin
        v = 1;
        v = v << $urandom_range(0, DW - 1);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_beat(logic [OpWidth-1:0] op, logic [DW-1:0] a, logic [DW-1:0] b);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = '0;
    s_axis_tdata[OpWidth+2*DW-1:0] = {b, a, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    book.note_request(op, a, b);
    @(negedge clk);
  endtask

  task automatic issue(logic [OpWidth-1:0] op, logic [DW-1:0] a, logic [DW-1:0] b);
    send_beat(op, a, b);
    if ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        m_axis_tready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_hold = 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) book.check_result(m_axis_tdata);
    if (!rst && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("alu_with_status_flags_core_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n;
    logic [OpWidth-1:0] op;
    logic [DW-1:0] a, b;
    book = new();
    idle_pct = 20;
    long_hold = 1'b0;
    quiet_cycles = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    issue(OP_ADD, MAX_VAL, 1);
    issue(OP_ADD, '0, '0);
    issue(OP_ADD, MIN_VAL, ALL_ONES);
    issue(OP_SUB, MIN_VAL, 1);
    issue(OP_SUB, '0, MIN_VAL);
    issue(OP_SUB, 5, 5);
    issue(OP_MUL, MAX_VAL, MAX_VAL);
    issue(OP_MUL, ALL_ONES, MIN_VAL);
    issue(OP_DIV, -7, 2);
    issue(OP_DIV, MIN_VAL, ALL_ONES);
    issue(OP_DIV, 7, '0);
    issue(OP_DIV, '0, -5);
    issue(OP_AND, ALL_ONES, MIN_VAL);
    issue(OP_OR, '0, '0);
    issue(OP_XOR, MAX_VAL, MIN_VAL);
    issue(OP_NOT, '0, $urandom);
    issue(OP_SHL, 1, 31);
    issue(OP_SHL, ALL_ONES, 32'hFFFF_FFE0);
    issue(OP_SHR, MIN_VAL, 31);
    issue(OP_SHR, ALL_ONES, 33);
    issue(OP_EQ, MIN_VAL, MIN_VAL);
    issue(OP_NEQ, '0, '0);
    issue(OP_GT, MAX_VAL, MIN_VAL);
    issue(OP_LT, MIN_VAL, MAX_VAL);
    issue(OP_GE, ALL_ONES, ALL_ONES);
    issue(OP_LE, 1, '0);

    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 40;
        endcase
        if (n >= CALM_FROM) idle_pct = 0;
      end
      if (n == 400) long_hold = 1'b1;
      if (n == 800) begin
        // drain: hold the input until every result is back
        s_axis_tvalid = 1'b0;
        while (book.expected_results.size() != 0) @(negedge clk);
      end
      op = OpWidth'($urandom_range(0, 15));
      a = pick_operand();
      b = pick_operand();
      issue(op, a, b);
    end
    s_axis_tvalid = 1'b0;

    while (book.expected_results.size() != 0) @(posedge clk);
    repeat (3 * DW) @(posedge clk);
    if (book.mismatches == 0 && book.expected_results.size() == 0) begin
      $display("alu_with_status_flags_core_tb: PASS");
    end else begin
      $display("alu_with_status_flags_core_tb: FAIL");
    end
    $finish;
  end

endmodule
